[design/kse_pkg.sv]
// ----------------------------------------------------------------------------
// kse_pkg
// Shared types and constants of the keypad scanner with code entry.
// ----------------------------------------------------------------------------
package kse_pkg;

  localparam int unsigned ColW   = 4;
  localparam int unsigned RowW   = 2;
  localparam int unsigned MapW   = 16;
  localparam int unsigned DigitW = 4;
  localparam int unsigned CodeW  = 44;
  localparam int unsigned EventW = 3;

  typedef enum logic [EventW-1:0] {
    EvNone     = 3'd0,
    EvDigit    = 3'd1,
    EvFuncA    = 3'd2,
    EvFuncB    = 3'd3,
    EvMatch    = 3'd4,
    EvMismatch = 3'd5
  } key_event_e;

  // Decode of the single held key on a fresh press.
  typedef struct packed {
    logic              dig_vld;
    logic [DigitW-1:0] digit;
    logic              func_a;
    logic              func_b;
    logic              check;
  } kse_dec_t;

endpackage

[design/kse_col_if.sv]
// ----------------------------------------------------------------------------
// kse_col_if
// Scan tick channel: column levels of the row driven low.
// ----------------------------------------------------------------------------
interface kse_col_if;
  logic       valid;
  logic       ready;
  logic [3:0] column_levels;

  modport source (output valid, output column_levels, input ready);
  modport sink (input valid, input column_levels, output ready);
endinterface

[design/kse_cfg_if.sv]
// ----------------------------------------------------------------------------
// kse_cfg_if
// Configuration write channel for the expected code.
// ----------------------------------------------------------------------------
interface kse_cfg_if;
  logic        valid;
  logic        ready;
  logic [43:0] expected_code;

  modport source (output valid, output expected_code, input ready);
  modport sink (input valid, input expected_code, output ready);
endinterface

[design/kse_res_if.sv]
// ----------------------------------------------------------------------------
// kse_res_if
// Result channel: row to drive, key map, event and entry register.
// ----------------------------------------------------------------------------
interface kse_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  drive_row;
  logic [15:0] key_map;
  logic [2:0]  key_event;
  logic [3:0]  entered_digit;
  logic [43:0] entered_code;

  modport source (output valid, output drive_row, output key_map, output key_event,
                  output entered_digit, output entered_code, input ready);
  modport sink (input valid, input drive_row, input key_map, input key_event,
                input entered_digit, input entered_code, output ready);
endinterface

[design/kse_keymap.sv]
// ----------------------------------------------------------------------------
// kse_keymap
// Row scan state, held-key map and single-key press decode.
// ----------------------------------------------------------------------------
module kse_keymap (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic [3:0]              cols_i,
  output logic [1:0]              row_d_o,
  output logic [15:0]             held_d_o,
  output kse_pkg::kse_dec_t       dec_o
);
  import kse_pkg::*;

  logic [RowW-1:0] scan_q, scan_d;
  logic [MapW-1:0] held_q, held_d;
  logic [ColW-1:0] pressed;
  logic            fresh;

  assign pressed = ~cols_i;
  assign scan_d  = scan_q + RowW'(1);

  // Replace the scanned row's nibble; held map doubles as last-scanned history.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (scan_q == RowW'(r)) begin
        held_d[r*ColW +: ColW] = pressed;
      end else begin
        held_d[r*ColW +: ColW] = held_q[r*ColW +: ColW];
      end
    end
  end

  assign fresh = |(pressed & ~held_q[scan_q*ColW +: ColW]);

  always_comb begin
    dec_o = '0;
    if (fresh) begin
      unique case (held_d)
        16'h0001: begin dec_o.dig_vld = 1'b1; dec_o.digit = 4'd7; end
        16'h0002: begin dec_o.dig_vld = 1'b1; dec_o.digit = 4'd4; end
        16'h0004: begin dec_o.dig_vld = 1'b1; dec_o.digit = 4'd1; end
        16'h0008: begin dec_o.dig_vld = 1'b1; dec_o.digit = 4'd0; end
        16'h0010: begin dec_o.dig_vld = 1'b1; dec_o.digit = 4'd8; end
        16'h0020: begin dec_o.dig_vld = 1'b1; dec_o.digit = 4'd5; end
        16'h0040: begin dec_o.dig_vld = 1'b1; dec_o.digit = 4'd2; end
        16'h0100: begin dec_o.dig_vld = 1'b1; dec_o.digit = 4'd9; end
        16'h0200: begin dec_o.dig_vld = 1'b1; dec_o.digit = 4'd6; end
        16'h0400: begin dec_o.dig_vld = 1'b1; dec_o.digit = 4'd3; end
        16'h1000: dec_o.func_a = 1'b1;
        16'h2000: dec_o.func_b = 1'b1;
        16'h8000: dec_o.check  = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      held_q <= '0;
    end else if (adv_i) begin
      scan_q <= scan_d;
      held_q <= held_d;
    end
  end

  assign row_d_o  = scan_d;
  assign held_d_o = held_d;

  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |=> scan_q == $past(scan_d))
    else $error("scan row did not advance");

  a_decode_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_o.dig_vld || dec_o.func_a || dec_o.func_b || dec_o.check) |-> $onehot(held_d))
    else $error("decode without exactly one held key");

endmodule

[design/kse_entry.sv]
// ----------------------------------------------------------------------------
// kse_entry
// BCD digit entry register, expected code register and code compare.
// ----------------------------------------------------------------------------
module kse_entry #(
  parameter int unsigned CodeDigits = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [kse_pkg::CodeW-1:0] cfg_code_i,
  input  logic                      adv_i,
  input  kse_pkg::kse_dec_t         dec_i,
  output logic [4*CodeDigits-1:0]   entry_d_o,
  output logic                      match_o
);
  import kse_pkg::*;

  localparam int unsigned EntryW = 4 * CodeDigits;
  localparam int unsigned CmpW   = (EntryW > CodeW) ? EntryW : CodeW;
  localparam logic [CmpW-1:0] CmpMask = (CmpW'(1) << EntryW) - CmpW'(1);

  logic [DigitW-1:0] dig_q [CodeDigits];
  logic [DigitW-1:0] dig_d [CodeDigits];
  logic [CodeW-1:0]  exp_q;
  logic [EntryW-1:0] entry_q;

  // Slot 0 holds the oldest digit; shift toward it, newest enters at the top.
  always_comb begin
    for (int k = 0; k < CodeDigits; k++) begin
      if (k == CodeDigits - 1) begin
        dig_d[k] = dec_i.digit;
      end else begin
        dig_d[k] = dig_q[k+1];
      end
      entry_q[DigitW*(CodeDigits-1-k) +: DigitW]   = dig_q[k];
      entry_d_o[DigitW*(CodeDigits-1-k) +: DigitW] = dec_i.dig_vld ? dig_d[k] : dig_q[k];
    end
  end

  assign match_o = (CmpW'(entry_q) == (CmpW'(exp_q) & CmpMask));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CodeDigits; k++) begin
        dig_q[k] <= '0;
      end
    end else if (adv_i && dec_i.dig_vld) begin
      for (int k = 0; k < CodeDigits; k++) begin
        dig_q[k] <= dig_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
    end else if (cfg_we_i) begin
      exp_q <= cfg_code_i;
    end
  end

  a_digit_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && dec_i.dig_vld |=> dig_q[CodeDigits-1] == $past(dec_i.digit))
    else $error("entered digit not stored");

  a_entry_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv_i && dec_i.dig_vld) |=> entry_q == $past(entry_q))
    else $error("entry changed without a digit");

endmodule

[design/keypad_scan_code_entry.sv]
// ----------------------------------------------------------------------------
// keypad_scan_code_entry
// 4x4 matrix keypad scanner with BCD code entry and code check.
// ----------------------------------------------------------------------------
// Path: an accepted scan tick goes to the input register, then the result
//   register; a stall on the result side holds it in the input register.
// Throughput: one tick per cycle unless stalled; map and entry update at once.
// Reset: row 0, empty key map, all entry digits and the expected code zero.
// ----------------------------------------------------------------------------
module keypad_scan_code_entry #(
  parameter int unsigned CodeDigits = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kse_col_if.sink     col_i,
  kse_cfg_if.sink     cfg_i,
  kse_res_if.source   res_o
);
  import kse_pkg::*;

  localparam int unsigned EntryW = 4 * CodeDigits;
  localparam int unsigned WideW  = (EntryW > CodeW) ? EntryW : CodeW;

  logic              in_vld_q;
  logic [ColW-1:0]   cols_q;
  logic              adv;
  logic              out_vld_q;

  logic [RowW-1:0]   row_d;
  logic [MapW-1:0]   held_d;
  kse_dec_t          dec;
  logic [EntryW-1:0] entry_d;
  logic [WideW-1:0]  entry_wide;
  logic              match;
  key_event_e        ev_d, ev_q;

  logic [RowW-1:0]   row_q;
  logic [MapW-1:0]   map_q;
  logic [DigitW-1:0] digit_q;
  logic [CodeW-1:0]  code_q;

  // Advance when the result register is free or being drained this cycle.
  assign adv         = in_vld_q && (!out_vld_q || res_o.ready);
  assign col_i.ready = !in_vld_q || adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (col_i.valid && col_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_i.valid && col_i.ready) begin
      cols_q <= col_i.column_levels;
    end
  end

  kse_keymap u_keymap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .cols_i   (cols_q),
    .row_d_o  (row_d),
    .held_d_o (held_d),
    .dec_o    (dec)
  );

  kse_entry #(
    .CodeDigits (CodeDigits)
  ) u_entry (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_code_i (cfg_i.expected_code),
    .adv_i      (adv),
    .dec_i      (dec),
    .entry_d_o  (entry_d),
    .match_o    (match)
  );

  always_comb begin
    priority if (dec.dig_vld) begin
      ev_d = EvDigit;
    end else if (dec.func_a) begin
      ev_d = EvFuncA;
    end else if (dec.func_b) begin
      ev_d = EvFuncB;
    end else if (dec.check) begin
      ev_d = match ? EvMatch : EvMismatch;
    end else begin
      ev_d = EvNone;
    end
  end

  assign entry_wide = WideW'(entry_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      row_q   <= row_d;
      map_q   <= held_d;
      ev_q    <= ev_d;
      digit_q <= dec.dig_vld ? dec.digit : '0;
      code_q  <= entry_wide[CodeW-1:0];
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.drive_row     = row_q;
  assign res_o.key_map       = map_q;
  assign res_o.key_event     = ev_q;
  assign res_o.entered_digit = digit_q;
  assign res_o.entered_code  = code_q;

  a_event_one_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && ev_q != EvNone |-> $onehot(map_q))
    else $error("event reported with other than one held key");

  a_digit_only_on_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && ev_q != EvDigit |-> digit_q == '0)
    else $error("digit shown without a digit event");

  a_digit_in_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && ev_q == EvDigit |-> code_q[DigitW-1:0] == digit_q)
    else $error("entered digit missing from entry register");

  a_advance_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("result register not loaded on advance");

endmodule
